// ----- rtl/dphd_pkg.sv -----
// ----------------------------------------------------------------------------
// dphd_pkg
// shared types, register codes and defaults of the harmonic phasor dft block
// ----------------------------------------------------------------------------
package dphd_pkg;

  localparam int WINDOW_LEN_DEF = 256;
  localparam int MAX_HARM_DEF   = 4;
  // the register file holds four harmonic numbers
  localparam int SLOT_LIMIT     = 4;

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // register indexes
  localparam logic [2:0] REG_HCOUNT = 3'd0;
  localparam logic [2:0] REG_HARM0  = 3'd1;
  localparam logic [2:0] REG_HARM1  = 3'd2;
  localparam logic [2:0] REG_HARM2  = 3'd3;
  localparam logic [2:0] REG_HARM3  = 3'd4;

  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] harm;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         cnt;
  } item_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [1:0]         slot;
    logic               last;
  } result_t;

endpackage

// ----- rtl/dphd_cfg.sv -----
// ----------------------------------------------------------------------------
// dphd_cfg
// apb register file: harmonic count and four harmonic numbers
// ----------------------------------------------------------------------------
module dphd_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output dphd_pkg::cfg_t cfg
);
  import dphd_pkg::*;

  logic [2:0]      count_r;
  logic [3:0][7:0] harm_r;
  logic [2:0]      idx;
  logic            wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd1;
      harm_r  <= {8'd0, 8'd0, 8'd0, 8'd1};
    end else if (wr_en) begin
      unique case (idx) inside
        REG_HCOUNT: count_r <= pwdata[2:0];
        REG_HARM0, REG_HARM1, REG_HARM2, REG_HARM3:
          harm_r[2'(idx - REG_HARM0)] <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx) inside
      REG_HCOUNT: prdata = {29'd0, count_r};
      REG_HARM0, REG_HARM1, REG_HARM2, REG_HARM3:
        prdata = {24'd0, harm_r[2'(idx - REG_HARM0)]};
      default: prdata = 32'd0;
    endcase
  end

  assign cfg.count = count_r;
  assign cfg.harm  = harm_r;

endmodule

// ----- rtl/dphd_front.sv -----
// ----------------------------------------------------------------------------
// dphd_front
// accepts samples, tags each with its clamped harmonic count, two-entry queue
// ----------------------------------------------------------------------------
module dphd_front #(
  parameter int MAX_HARMONICS = dphd_pkg::MAX_HARM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic signed [15:0]  sample,
  input  logic [2:0]          count,
  output logic                full,
  input  logic                q_pop,
  output logic                q_empty,
  output dphd_pkg::item_t     q_item
);
  import dphd_pkg::*;

  localparam int NUM_SLOTS = (MAX_HARMONICS < SLOT_LIMIT) ? MAX_HARMONICS : SLOT_LIMIT;

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;
  logic       do_push, do_pop;
  logic [2:0] cnt_eff;

  assign cnt_eff = (count > 3'(NUM_SLOTS)) ? 3'(NUM_SLOTS) : count;
  assign full    = (fill_r == 2'd2);
  assign q_empty = (fill_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && !q_empty;
  assign q_item  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r].sample <= sample;
      ent_r[wp_r].cnt    <= cnt_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      fill_r <= fill_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/dphd_outq.sv -----
// ----------------------------------------------------------------------------
// dphd_outq
// two-entry result queue between the dft engine and the result ports
// ----------------------------------------------------------------------------
module dphd_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  dphd_pkg::result_t wr_data,
  output logic              q_full,
  input  logic              pop,
  output logic              empty,
  output dphd_pkg::result_t head
);
  import dphd_pkg::*;

  result_t    ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;
  logic       do_wr, do_pop;

  assign q_full = (fill_r == 2'd2);
  assign empty  = (fill_r == 2'd0);
  assign do_wr  = wr_en && !q_full;
  assign do_pop = pop && !empty;
  assign head   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) ent_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (do_wr)  wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      fill_r <= fill_r + 2'(do_wr) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/dphd_engine.sv -----
// ----------------------------------------------------------------------------
// dphd_engine
// window memory, twiddle rom, multiply-accumulate loop and rounding shift
// ----------------------------------------------------------------------------
module dphd_engine #(
  parameter int WINDOW_LEN = dphd_pkg::WINDOW_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dphd_pkg::cfg_t    cfg,
  input  logic              iq_empty,
  input  dphd_pkg::item_t   iq_item,
  output logic              iq_pop,
  input  logic              oq_full,
  output logic              oq_push,
  output dphd_pkg::result_t oq_data
);
  import dphd_pkg::*;

  localparam int AW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int HW    = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int ACC_W = 48 + AW;
  // divide by window length * 2^15, window length a power of two
  localparam int SH    = AW + 15;
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_LEN - 1);
  localparam logic [AW-1:0] A_START  = AW'(2 % WINDOW_LEN);
  localparam logic signed [ACC_W-1:0] HALF_D = ACC_W'(WINDOW_LEN) <<< 14;

  function automatic logic [63:0] tw_pair(input logic [63:0] theta, input logic [1:0] quad);
    logic [63:0]        t;
    logic [63:0]        prod;
    logic signed [63:0] c, s;
    logic signed [31:0] cc, ss;
    t = ONE_Q30;
    c = $signed(ONE_Q30);
    s = 64'sd0;
    for (int k = 1; k <= 20; k++) begin
      prod = t * theta;
      t = (prod >> 30) / 64'(k);
      case (k % 4)
        1:       s = s + $signed(t);
        2:       c = c - $signed(t);
        3:       s = s - $signed(t);
        default: c = c + $signed(t);
      endcase
    end
    if (c < 0) c = 64'sd0;
    if (c > $signed(ONE_Q30)) c = $signed(ONE_Q30);
    if (s < 0) s = 64'sd0;
    if (s > $signed(ONE_Q30)) s = $signed(ONE_Q30);
    case (quad)
      2'd0:    begin cc = 32'(c);  ss = 32'(s);  end
      2'd1:    begin cc = -32'(s); ss = 32'(c);  end
      2'd2:    begin cc = -32'(c); ss = -32'(s); end
      default: begin cc = 32'(s);  ss = -32'(c); end
    endcase
    return {cc, ss};
  endfunction

  logic signed [31:0] rom_cos [WINDOW_LEN];
  logic signed [31:0] rom_sin [WINDOW_LEN];

  for (genvar p = 0; p < WINDOW_LEN; p++) begin : g_rom
    localparam int U = 4 * p;
    localparam int Q = U / WINDOW_LEN;
    localparam int R = U % WINDOW_LEN;
    localparam logic [63:0] TH =
      (PI_HALF_Q30 * 64'(R) + 64'(WINDOW_LEN / 2)) / 64'(WINDOW_LEN);
    localparam logic [63:0] TW = tw_pair(TH, 2'(Q));
    assign rom_cos[p] = TW[63:32];
    assign rom_sin[p] = TW[31:0];
  end

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HMOD = 6'b000010,
    S_RUN  = 6'b000100,
    S_DRN  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] win_mem [WINDOW_LEN];

  logic [AW-1:0] step_r, thr_r;
  logic [2:0]    cnt_r;
  logic [1:0]    slot_r;
  logic [HW-1:0] hm_r;
  logic [AW-1:0] j_r, a_r, n_r, idx_r;

  logic signed [15:0] x_r;
  logic signed [31:0] c_r, s_r;
  logic               v1_r, m1_r, v2_r;
  logic signed [47:0] pr_re_r, pr_im_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0] rnd_re, rnd_im;
  logic signed [31:0] q_re_r, q_im_r;

  logic          pop_go, last_slot, emit_go, finish;
  logic [AW-1:0] n_start;
  logic [AW:0]   idx_sum;

  assign pop_go    = state_r[0] && !iq_empty;
  assign iq_pop    = pop_go;
  assign last_slot = (3'(slot_r) + 3'd1 == cnt_r);
  assign emit_go   = (state_r == S_EMIT) && !oq_full;
  assign oq_push   = emit_go;
  assign finish    = (pop_go && iq_item.cnt == 3'd0) || (emit_go && last_slot);
  assign idx_sum   = {1'b0, idx_r} + (AW + 1)'(hm_r);
  assign rnd_re    = acc_re_r + HALF_D;
  assign rnd_im    = acc_im_r + HALF_D;

  // position of window entry paired with phase zero
  always_comb begin
    if (step_r == '0)
      n_start = AW'(1 % WINDOW_LEN);
    else if (step_r == AW'(1))
      n_start = '0;
    else
      n_start = AW'((AW + 1)'(WINDOW_LEN + 1) - {1'b0, step_r});
  end

  assign oq_data.re   = q_re_r;
  assign oq_data.im   = q_im_r;
  assign oq_data.slot = slot_r;
  assign oq_data.last = last_slot;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (pop_go && iq_item.cnt != 3'd0) state_nxt = S_HMOD;
      S_HMOD: if (hm_r < HW'(WINDOW_LEN)) state_nxt = S_RUN;
      S_RUN:  if (j_r == LAST_IDX) state_nxt = S_DRN;
      S_DRN:  if (!v1_r && !v2_r) state_nxt = S_DIV;
      S_DIV:  state_nxt = S_EMIT;
      S_EMIT: if (emit_go) state_nxt = last_slot ? S_IDLE : S_HMOD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      thr_r   <= LAST_IDX;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == S_RUN);
      v2_r    <= v1_r;
      if (finish) begin
        step_r <= (step_r == LAST_IDX) ? '0 : step_r + AW'(1);
        if (thr_r != '0) thr_r <= thr_r - AW'(1);
      end
    end
  end

  // window store: sample k goes to entry k mod window length
  always_ff @(posedge clk) begin
    if (pop_go) win_mem[step_r] <= iq_item.sample;
    x_r <= win_mem[a_r];
    c_r <= rom_cos[idx_r];
    s_r <= rom_sin[idx_r];
    m1_r <= (n_r >= thr_r);
    pr_re_r <= m1_r ? x_r * c_r : 48'sd0;
    pr_im_r <= m1_r ? x_r * s_r : 48'sd0;
  end

  always_ff @(posedge clk) begin
    if (pop_go) begin
      cnt_r  <= iq_item.cnt;
      slot_r <= 2'd0;
      hm_r   <= HW'(cfg.harm[0]);
    end
    if (emit_go && !last_slot) begin
      slot_r <= slot_r + 2'd1;
      hm_r   <= HW'(cfg.harm[slot_r + 2'd1]);
    end
    if (state_r == S_HMOD) begin
      if (hm_r >= HW'(WINDOW_LEN)) begin
        hm_r <= hm_r - HW'(WINDOW_LEN);
      end else begin
        j_r      <= '0;
        a_r      <= A_START;
        n_r      <= n_start;
        idx_r    <= '0;
        acc_re_r <= '0;
        acc_im_r <= '0;
      end
    end
    if (state_r == S_RUN) begin
      j_r   <= j_r + AW'(1);
      a_r   <= (a_r == LAST_IDX) ? '0 : a_r + AW'(1);
      n_r   <= (n_r == LAST_IDX) ? '0 : n_r + AW'(1);
      idx_r <= (idx_sum >= (AW + 1)'(WINDOW_LEN)) ?
               AW'(idx_sum - (AW + 1)'(WINDOW_LEN)) : AW'(idx_sum);
    end
    if (v2_r) begin
      acc_re_r <= acc_re_r + ACC_W'(pr_re_r);
      acc_im_r <= acc_im_r + ACC_W'(pr_im_r);
    end
    // round half up, then floor by arithmetic shift
    if (state_r == S_DIV) begin
      q_re_r <= 32'(rnd_re >>> SH);
      q_im_r <= 32'(rnd_im >>> SH);
    end
  end

endmodule

// ----- rtl/dynamic_phasor_harmonic_dft_top.sv -----
// ----------------------------------------------------------------------------
// dynamic_phasor_harmonic_dft_top
// windowed dft harmonic phasor estimator with apb configuration
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// input     in         push / full            in_sample_in
// result    out        empty / pop            out_phasor_real, out_phasor_imag,
//                                             out_harmonic_slot, out_last_of_run
// config    in/out     psel penable pwrite    paddr, pwdata, prdata, pready
//
// per sample: a pop from the input queue, then for each active harmonic in turn
// modulo reduction, one mac per window entry in a single mac loop over the
// window memory port, pipeline drain, rounding shift and emit
// window length is a power of two so the scaling is a shift
// reset: window is marked empty by a fill threshold, no clearing pass
// input and result queues hold two entries each and stall independently
// ----------------------------------------------------------------------------
module dynamic_phasor_harmonic_dft_top #(
  parameter int WINDOW_LEN    = dphd_pkg::WINDOW_LEN_DEF,
  parameter int MAX_HARMONICS = dphd_pkg::MAX_HARM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_sample_in,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_phasor_real,
  output logic signed [31:0] out_phasor_imag,
  output logic [1:0]         out_harmonic_slot,
  output logic               out_last_of_run,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dphd_pkg::*;

  cfg_t    cfg;
  item_t   iq_item;
  result_t oq_data, head;
  logic    iq_empty, iq_pop, oq_full, oq_push;

  dphd_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  dphd_front #(.MAX_HARMONICS(MAX_HARMONICS)) u_front (
    .clk, .rst_n, .push, .sample(in_sample_in), .count(cfg.count), .full,
    .q_pop(iq_pop), .q_empty(iq_empty), .q_item(iq_item)
  );

  dphd_engine #(.WINDOW_LEN(WINDOW_LEN)) u_engine (
    .clk, .rst_n, .cfg, .iq_empty, .iq_item, .iq_pop, .oq_full, .oq_push, .oq_data
  );

  dphd_outq u_outq (
    .clk, .rst_n, .wr_en(oq_push), .wr_data(oq_data), .q_full(oq_full),
    .pop, .empty, .head
  );

  assign out_phasor_real   = head.re;
  assign out_phasor_imag   = head.im;
  assign out_harmonic_slot = head.slot;
  assign out_last_of_run   = head.last;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives samples through the harmonic phasor dft block, predicts every
// phasor from a local twiddle table and sliding window, and compares each
// result transfer against the oldest predicted one
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dphd_pkg::*;

  localparam int N = WINDOW_LEN_DEF;
  localparam int SLOTS = (MAX_HARM_DEF < 4) ? MAX_HARM_DEF : 4;
  localparam int DRAIN = 4 * (N + 40) + 50;
  localparam int WATCHDOG = 20 * (4 * (N + 40)) + 5000;

  class phasor_board;
    result_t pending[$];
    int mismatches;
    int fails;
    logic signed [31:0] tw_cos [N];
    logic signed [31:0] tw_sin [N];
    logic signed [15:0] win [N];
    int phase;
    int hcount;
    int harm [4];

    function new();
      longint unsigned u, q, r, theta, t;
      longint c, s;
      for (int p = 0; p < N; p++) begin
        u = 4 * p;
        q = u / N;
        r = u % N;
        theta = (PI_HALF_Q30 * r + N / 2) / N;
        t = ONE_Q30;
        c = ONE_Q30;
        s = 0;
        for (int k = 1; k <= 20; k++) begin
          t = ((t * theta) >> 30) / k;
          case (k % 4)
            1: s += t;
            2: c -= t;
            3: s -= t;
            default: c += t;
          endcase
        end
        if (c < 0) c = 0;
        if (c > ONE_Q30) c = ONE_Q30;
        if (s < 0) s = 0;
        if (s > ONE_Q30) s = ONE_Q30;
        case (q % 4)
          0: begin tw_cos[p] = 32'(c); tw_sin[p] = 32'(s); end
          1: begin tw_cos[p] = 32'(-s); tw_sin[p] = 32'(c); end
          2: begin tw_cos[p] = 32'(-c); tw_sin[p] = 32'(-s); end
          default: begin tw_cos[p] = 32'(s); tw_sin[p] = 32'(-c); end
        endcase
      end
      foreach (win[i]) win[i] = 0;
      phase = 0;
      hcount = 1;
      harm = '{1, 0, 0, 0};
    endfunction

    function void write_reg(int idx, int val);
      if (idx == REG_HCOUNT) hcount = val & 7;
      else if (idx <= REG_HARM3) harm[idx - 1] = val & 255;
    endfunction

    function longint rdiv(longint s);
      longint d, num, q;
      d = longint'(N) * 32768;
      num = s + d / 2;
      q = num / d;
      if (num % d < 0) q--;
      return q;
    endfunction

    function void note_sample(logic signed [15:0] x);
      int cnt, e, idx;
      longint sr, si;
      result_t rs;
      for (int i = 0; i < N - 1; i++) win[i] = win[i + 1];
      win[N - 1] = x;
      cnt = (hcount > SLOTS) ? SLOTS : hcount;
      for (int k = 0; k < cnt; k++) begin
        sr = 0;
        si = 0;
        for (int n = 0; n < N; n++) begin
          e = (n + phase + N - 1) % N;
          idx = (harm[k] * e) % N;
          sr += longint'(win[n]) * longint'(tw_cos[idx]);
          si += longint'(win[n]) * longint'(tw_sin[idx]);
        end
        rs.re = 32'(rdiv(sr));
        rs.im = 32'(rdiv(si));
        rs.slot = 2'(k);
        rs.last = (k + 1 == cnt);
        pending.push_back(rs);
      end
      phase = (phase + 1) % N;
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        fails++;
        if (mismatches++ < 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        fails++;
        if (mismatches++ < 10)
          $display("mismatch: expected re=%0d im=%0d slot=%0d last=%0d, got re=%0d im=%0d slot=%0d last=%0d",
                   exp_r.re, exp_r.im, exp_r.slot, exp_r.last,
                   got.re, got.im, got.slot, got.last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0;
  logic full;
  logic signed [15:0] in_sample_in = 0;
  logic empty;
  logic pop = 0;
  logic signed [31:0] out_phasor_real, out_phasor_imag;
  logic [1:0] out_harmonic_slot;
  logic out_last_of_run;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  phasor_board board = new();
  int send_idle = 6;
  int recv_idle = 74;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  dynamic_phasor_harmonic_dft_top u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_sample_in(in_sample_in),
    .empty(empty), .pop(pop), .out_phasor_real(out_phasor_real),
    .out_phasor_imag(out_phasor_imag), .out_harmonic_slot(out_harmonic_slot),
    .out_last_of_run(out_last_of_run), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // result side: pop decided at falling edge, transfer sampled at rising edge
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      board.check_result('{out_phasor_real, out_phasor_imag, out_harmonic_slot,
                           out_last_of_run});
  end
  always @(negedge clk) pop <= ($urandom_range(99) >= recv_idle);

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // push is lowered once a transfer is seen and raised again when send_sample is called for another sample
  task automatic send_sample(logic signed [15:0] x);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    push = 1;
    in_sample_in <= x;
    do @(posedge clk); while (full);
    board.note_sample(x);
    @(negedge clk);
    push = 0;
  endtask

  task automatic wait_idle();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, int val);
    psel <= 1;
    pwrite <= 1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, val);
    @(negedge clk);
    penable <= 0;
  endtask

  task automatic set_harmonics(int cnt, int h0, int h1, int h2, int h3);
    wait_idle();
    reg_write(REG_HCOUNT, cnt);
    reg_write(REG_HARM0, h0);
    reg_write(REG_HARM1, h1);
    reg_write(REG_HARM2, h2);
    reg_write(REG_HARM3, h3);
    psel <= 0;
    pwrite <= 0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // reset configuration first: one harmonic, number one
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(0);
    send_sample(-1);
    set_harmonics(4, 0, 255, 128, 7);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    // zero count: accepted, no results
    set_harmonics(0, 3, 3, 3, 3);
    send_sample(16'sh1234);
    send_sample(-16'sd300);
    // count above the slots saturates
    set_harmonics(7, 1, 2, 3, 4);
    send_sample(16'sh7fff);
    send_sample(16'sh0001);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 6 : (ph == 1) ? 74 : 0;
      recv_idle = (ph == 0) ? 74 : (ph == 1) ? 6 : 0;
      set_harmonics($urandom_range(7), $urandom_range(255), $urandom_range(255),
                    $urandom_range(255), $urandom_range(255));
      for (int i = 0; i < 40; i++) begin
        if (i == 20) set_harmonics($urandom_range(1, 4), $urandom_range(255),
                                   $urandom_range(255), $urandom_range(255),
                                   $urandom_range(255));
        if (i == 10) while (board.pending.size() != 0) @(negedge clk);
        send_sample(rand_sample());
      end
    end
    wait_idle();
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
